[hw/rtl/spm_pkg.sv]
// Package for the SPI master peripheral: shared types, codes and status bit positions.
// Has no dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package spm_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_CPOL      = 3'd1,
    CFG_CPHA      = 3'd2,
    CFG_BAUD      = 3'd3,
    CFG_FRAME16   = 3'd4,
    CFG_LSB_FIRST = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DataW    = 16;
  localparam int unsigned DivW     = 8;
  localparam int unsigned BitCntW  = 5;

  localparam int unsigned SrRxneBit = 0;
  localparam int unsigned SrTxeBit  = 1;
  localparam int unsigned SrOvrBit  = 6;
  localparam int unsigned SrBsyBit  = 7;

  typedef struct packed {
    logic       enable;
    logic       cpol;
    logic       cpha;
    logic [2:0] baud_select;
    logic       frame_16bit;
    logic       lsb_first;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [DataW-1:0] tx_data;
    logic             miso;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             sck;
    logic             mosi;
    logic             tx_empty;
    logic             rx_not_empty;
    logic             overrun;
    logic             busy;
  } result_t;

  typedef struct packed {
    logic [DataW-1:0]   tx_buffer;
    logic               tx_full;
    logic [DataW-1:0]   shift_reg;
    logic [DataW-1:0]   rx_buffer;
    logic               rx_full;
    logic               overrun_flag;
    logic [BitCntW-1:0] bit_count;
    logic [DivW-1:0]    divider_count;
    logic               clock_level;
    logic               shifting;
    logic               sample_bit;
  } state_t;

endpackage

[hw/rtl/spi_master_peripheral_unit.sv]
// Top level of the SPI master peripheral: input register, tick engine, result register.
// Depends on spm_pkg, spm_cfg, spm_in_stage, spm_core and spm_out_stage.
//
// Each input transaction is one peripheral clock tick carrying an operation (tick only,
// data write, data read or status read), a transmit word and the sampled MISO level.
// Each tick yields exactly one result transaction: the read word or status word, the
// SCK and MOSI levels after the tick, and the TXE, RXNE, overrun and busy flags.
// The tick sits in the input register while the tick engine computes the new peripheral
// state; the engine's state register and the result register load together when the result
// register can take it. Throughput is one tick per cycle while the receiver does not stall;
// the rate is set by the engine updating its state for every tick as its result loads.
// When out_stall_i holds a result, the result register keeps it, the input register
// keeps a tick it holds and in_stall_o rises; a fresh tick is still taken while the result
// register is full but about to drain.
// Configuration writes use cfg_valid_i, cfg_ready_o, cfg_index_i and cfg_wdata_i; the user
// must make them only while no tick is in flight; the block does not enforce it. Reset
// clears all configuration, buffers, shifter and flags; ticks are accepted right after it.
`timescale 1ns / 1ps

module spi_master_peripheral_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [spm_pkg::DataW-1:0]     tx_data_i,
  input  logic                          miso_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spm_pkg::DataW-1:0]     read_data_o,
  output logic                          sck_o,
  output logic                          mosi_o,
  output logic                          tx_empty_o,
  output logic                          rx_not_empty_o,
  output logic                          overrun_o,
  output logic                          busy_res_o
);

  spm_pkg::cfg_t    cfg;
  spm_pkg::item_t   item_in;
  spm_pkg::item_t   item_q;
  spm_pkg::result_t result_d;
  spm_pkg::result_t result_q;
  spm_pkg::state_t  state;
  logic             item_valid;
  logic             can_load;
  logic             advance;

  assign item_in.op      = op_i;
  assign item_in.tx_data = tx_data_i;
  assign item_in.miso    = miso_i;
  assign advance         = item_valid && can_load;

  spm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  spm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .take_i     (can_load),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  spm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (result_d),
    .state_o   (state)
  );

  spm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (item_valid),
    .result_i    (result_d),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  assign read_data_o    = result_q.read_data;
  assign sck_o          = result_q.sck;
  assign mosi_o         = result_q.mosi;
  assign tx_empty_o     = result_q.tx_empty;
  assign rx_not_empty_o = result_q.rx_not_empty;
  assign overrun_o      = result_q.overrun;
  assign busy_res_o     = result_q.busy;

  // The input side only stalls while a result is held back by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A word waiting in the transmit buffer always counts as busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_res_o || tx_empty_o))
    else $error("pending transmit word not reported as busy");

  // An idle shifter keeps its bit and divider counters cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state.shifting |-> (state.bit_count == '0 && state.divider_count == '0))
    else $error("idle shifter with nonzero counters");

endmodule

[hw/rtl/spm_cfg.sv]
// Configuration register file of the SPI master peripheral.
// Depends on spm_pkg for the register index codes and the configuration struct.
`timescale 1ns / 1ps

module spm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output spm_pkg::cfg_t                 cfg_o
);

  spm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spm_pkg::CFG_ENABLE:    cfg_d.enable      = cfg_wdata_i[0];
        spm_pkg::CFG_CPOL:      cfg_d.cpol        = cfg_wdata_i[0];
        spm_pkg::CFG_CPHA:      cfg_d.cpha        = cfg_wdata_i[0];
        spm_pkg::CFG_BAUD:      cfg_d.baud_select = cfg_wdata_i[2:0];
        spm_pkg::CFG_FRAME16:   cfg_d.frame_16bit = cfg_wdata_i[0];
        spm_pkg::CFG_LSB_FIRST: cfg_d.lsb_first   = cfg_wdata_i[0];
        default:                cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hw/rtl/spm_in_stage.sv]
// Input register of the SPI master peripheral: holds one accepted tick transaction.
// Depends on spm_pkg for the item struct.
`timescale 1ns / 1ps

module spm_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spm_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output spm_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  spm_pkg::item_t item_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

endmodule

[hw/rtl/spm_core.sv]
// Tick engine of the SPI master peripheral: register access, shifter step and frame start.
// Holds the peripheral state; depends on spm_pkg for the item, state and result types.
`timescale 1ns / 1ps

module spm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  spm_pkg::item_t   item_i,
  input  spm_pkg::cfg_t    cfg_i,
  output spm_pkg::result_t result_o,
  output spm_pkg::state_t  state_o
);

  spm_pkg::state_t state_q, state_d;

  logic [spm_pkg::DataW-1:0]   rd;
  logic [spm_pkg::DataW-1:0]   fmask;
  logic [spm_pkg::DivW-1:0]    div_inc;
  logic [spm_pkg::DivW-1:0]    half_period;
  logic [spm_pkg::BitCntW-1:0] bc_inc;
  logic [spm_pkg::BitCntW-1:0] nbits;
  logic                        leading;
  logic                        last;

  function automatic logic [spm_pkg::DataW-1:0] shift_in(
    input logic [spm_pkg::DataW-1:0] r,
    input logic                      b,
    input logic                      f16,
    input logic                      lsb
  );
    logic [spm_pkg::DataW-1:0] res;
    if (lsb) begin
      res = f16 ? {b, r[15:1]} : {8'h00, b, r[7:1]};
    end else begin
      res = f16 ? {r[14:0], b} : {8'h00, r[6:0], b};
    end
    return res;
  endfunction

  assign fmask       = cfg_i.frame_16bit ? 16'hFFFF : 16'h00FF;
  assign nbits       = cfg_i.frame_16bit ? 5'd16 : 5'd8;
  assign half_period = spm_pkg::DivW'(1) << cfg_i.baud_select;
  assign state_o     = state_q;

  always_comb begin
    state_d = state_q;
    rd      = '0;
    div_inc = state_q.divider_count + spm_pkg::DivW'(1);
    bc_inc  = state_q.bit_count + spm_pkg::BitCntW'(1);
    leading = (state_q.clock_level == cfg_i.cpol);
    last    = 1'b0;

    unique case (spm_pkg::op_e'(item_i.op))
      spm_pkg::OP_TICK: begin
      end
      spm_pkg::OP_WRITE: begin
        state_d.tx_buffer = item_i.tx_data;
        state_d.tx_full   = 1'b1;
      end
      spm_pkg::OP_READ: begin
        rd              = state_q.rx_buffer;
        state_d.rx_full = 1'b0;
      end
      spm_pkg::OP_STATUS: begin
        rd[spm_pkg::SrRxneBit] = state_q.rx_full;
        rd[spm_pkg::SrTxeBit]  = !state_q.tx_full;
        rd[spm_pkg::SrOvrBit]  = state_q.overrun_flag;
        rd[spm_pkg::SrBsyBit]  = state_q.shifting || state_q.tx_full;
        state_d.overrun_flag   = 1'b0;
      end
      default: begin
      end
    endcase

    if (state_q.shifting) begin
      if (div_inc < half_period) begin
        state_d.divider_count = div_inc;
      end else begin
        state_d.divider_count = '0;
        state_d.clock_level   = !state_q.clock_level;
        if (leading) begin
          if (!cfg_i.cpha) begin
            state_d.sample_bit = item_i.miso;
          end else if (state_q.bit_count != '0) begin
            state_d.shift_reg = shift_in(state_q.shift_reg, state_q.sample_bit,
                                         cfg_i.frame_16bit, cfg_i.lsb_first);
          end
        end else begin
          state_d.bit_count = bc_inc;
          last              = (bc_inc >= nbits);
          if (!cfg_i.cpha) begin
            state_d.shift_reg = shift_in(state_q.shift_reg, state_q.sample_bit,
                                         cfg_i.frame_16bit, cfg_i.lsb_first);
          end else if (last) begin
            state_d.shift_reg = shift_in(state_q.shift_reg, item_i.miso,
                                         cfg_i.frame_16bit, cfg_i.lsb_first);
          end else begin
            state_d.sample_bit = item_i.miso;
          end
          if (last) begin
            if (state_d.rx_full) begin
              state_d.overrun_flag = 1'b1;
            end else begin
              state_d.rx_buffer = state_d.shift_reg & fmask;
              state_d.rx_full   = 1'b1;
            end
            state_d.shifting      = 1'b0;
            state_d.clock_level   = cfg_i.cpol;
            state_d.bit_count     = '0;
            state_d.divider_count = '0;
          end
        end
      end
    end

    if (!state_d.shifting && state_d.tx_full && cfg_i.enable) begin
      state_d.shift_reg     = state_d.tx_buffer & fmask;
      state_d.tx_full       = 1'b0;
      state_d.shifting      = 1'b1;
      state_d.bit_count     = '0;
      state_d.divider_count = '0;
      state_d.clock_level   = cfg_i.cpol;
      state_d.sample_bit    = 1'b0;
    end
  end

  always_comb begin
    result_o.read_data    = rd;
    result_o.sck          = state_d.shifting ? state_d.clock_level : cfg_i.cpol;
    result_o.mosi         = 1'b0;
    if (state_d.shifting) begin
      if (cfg_i.lsb_first) begin
        result_o.mosi = state_d.shift_reg[0];
      end else begin
        result_o.mosi = cfg_i.frame_16bit ? state_d.shift_reg[15] : state_d.shift_reg[7];
      end
    end
    result_o.tx_empty     = !state_d.tx_full;
    result_o.rx_not_empty = state_d.rx_full;
    result_o.overrun      = state_d.overrun_flag;
    result_o.busy         = state_d.shifting || state_d.tx_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/spm_out_stage.sv]
// Result register of the SPI master peripheral: holds one result until the receiver takes it.
// Depends on spm_pkg for the result struct.
`timescale 1ns / 1ps

module spm_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  spm_pkg::result_t result_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spm_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  spm_pkg::result_t result_q;

  assign can_load_o  = !valid_q || !out_stall_i;
  assign valid_d     = can_load_o ? load_i : valid_q;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      result_q <= result_i;
    end
  end

endmodule
